// ----- hdl/pdmp_pkg.sv -----
// Package for the polar motor position pipeline.
// Payload structs, pipeline stage struct, fixed-point constants, arctangent table.
// Depends on nothing.
package pdmp_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int ITER_STAGES  = 32;   // sqrt yields one root bit per stage
   localparam int CSTEPS = (CORDIC_STEPS > ITER_STAGES) ? ITER_STAGES : CORDIC_STEPS;

   localparam int CX_W = 34;           // CORDIC x/y, covers the gain
   localparam int Z_W  = 34;           // angle accumulator and unwrap math
   localparam int T_W  = 50;           // gantry sum before clipping

   localparam logic signed [Z_W-1:0] ANG_PI      = Z_W'(421657428);
   localparam logic signed [Z_W-1:0] ANG_TWO_PI  = Z_W'(843314857);
   localparam logic signed [Z_W-1:0] ANG_HALF_PI = Z_W'(210828714);
   localparam logic [63:0]           DEAD_ZONE_R2 = 64'd429497;

   localparam logic [1:0] KIND_BED   = 2'd0;
   localparam logic [1:0] KIND_PLUS  = 2'd1;
   localparam logic [1:0] KIND_MINUS = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   localparam logic [1:0] CSR_MOTOR_KIND = 2'd0;
   localparam logic [1:0] CSR_B_RATIO    = 2'd1;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'd105414357, 32'd62229729, 32'd32880480, 32'd16690645, 32'd8377711,
      32'd4192939, 32'd2096981, 32'd1048555, 32'd524285, 32'd262144, 32'd131072,
      32'd65536, 32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024,
      32'd512, 32'd256, 32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2,
      32'd1, 32'd0, 32'd0, 32'd0, 32'd0
   };

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] rot_b;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] reference_angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] motor_position;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [CX_W-1:0] cx;
      logic signed [CX_W-1:0] cy;
      logic signed [Z_W-1:0]  z;
      logic                   origin;
      logic                   flip;
      logic [63:0]            sq_v;
      logic [34:0]            sq_rem;
      logic [31:0]            sq_q;
      logic signed [47:0]     bterm;
      logic signed [31:0]     ref_ang;
   } iter_type;

endpackage

// ----- hdl/pdmp_iter.sv -----
// Iteration pipeline: one square-root bit per stage, and one CORDIC vectoring step in each of the first CSTEPS stages.
// Depends on pdmp_pkg.
module pdmp_iter (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  pdmp_pkg::iter_type in_data,
   output logic               out_valid,
   output pdmp_pkg::iter_type out_data
);

   pdmp_pkg::iter_type                   d_ff [pdmp_pkg::ITER_STAGES];
   logic [pdmp_pkg::ITER_STAGES-1:0]     v_ff;

   for (genvar k = 0; k < pdmp_pkg::ITER_STAGES; k++) begin : g_st
      pdmp_pkg::iter_type src;
      pdmp_pkg::iter_type d_in;
      logic               src_v;
      logic [34:0]        rem2;
      logic [34:0]        trial;

      if (k == 0) begin : g_first
         assign src   = in_data;
         assign src_v = in_valid;
      end else begin : g_next
         assign src   = d_ff[k-1];
         assign src_v = v_ff[k-1];
      end

      assign rem2  = {src.sq_rem[32:0], src.sq_v[63:62]};
      assign trial = {1'b0, src.sq_q, 2'b01};

      always_comb begin
         d_in = src;
         if (k < pdmp_pkg::CSTEPS) begin
            if (src.cy > 0) begin
               d_in.cx = src.cx + (src.cy >>> k);
               d_in.cy = src.cy - (src.cx >>> k);
               d_in.z  = src.z + $signed(pdmp_pkg::Z_W'(pdmp_pkg::ATAN_TAB[k]));
            end else begin
               d_in.cx = src.cx - (src.cy >>> k);
               d_in.cy = src.cy + (src.cx >>> k);
               d_in.z  = src.z - $signed(pdmp_pkg::Z_W'(pdmp_pkg::ATAN_TAB[k]));
            end
         end
         d_in.sq_v = {src.sq_v[61:0], 2'b00};
         if (rem2 >= trial) begin
            d_in.sq_rem = rem2 - trial;
            d_in.sq_q   = {src.sq_q[30:0], 1'b1};
         end else begin
            d_in.sq_rem = rem2;
            d_in.sq_q   = {src.sq_q[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (advance) begin
            v_ff[k] <= src_v;
         end
         if (advance) begin
            d_ff[k] <= d_in;
         end
      end
   end

   assign out_valid = v_ff[pdmp_pkg::ITER_STAGES-1];
   assign out_data  = d_ff[pdmp_pkg::ITER_STAGES-1];

endmodule

// ----- hdl/polar_differential_motor_position.sv -----
// Polar motor position: one toolhead point in, one motor position out per cycle while not stalled.
// Stages in order: products, setup, 32 iteration stages set by the
// 32-bit square root, angle/sum, output register; a new point is taken
// every cycle unless the result register is stalled. Depends on pdmp_pkg, pdmp_iter.
module polar_differential_motor_position (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pdmp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pdmp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   logic [1:0]         kind_ff;
   logic signed [31:0] b_ratio_ff;
   logic               advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= pdmp_pkg::KIND_BED;
         b_ratio_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == pdmp_pkg::CSR_MOTOR_KIND) begin
            kind_ff <= csr_data[1:0];
         end else if (csr_index == pdmp_pkg::CSR_B_RATIO) begin
            b_ratio_ff <= csr_data;
         end
      end
   end

   // whole pipeline moves unless a finished result is held
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // stage 1: products
   logic               s1_v_ff;
   logic signed [63:0] s1_xx_ff, s1_yy_ff, s1_xdx_ff, s1_ydy_ff, s1_bp_ff;
   pdmp_pkg::req_type  s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= req_valid;
      end
      if (advance) begin
         s1_xx_ff  <= req_data.pos_x * req_data.pos_x;
         s1_yy_ff  <= req_data.pos_y * req_data.pos_y;
         s1_xdx_ff <= req_data.pos_x * req_data.dir_x;
         s1_ydy_ff <= req_data.pos_y * req_data.dir_y;
         s1_bp_ff  <= b_ratio_ff * req_data.rot_b;
         s1_req_ff <= req_data;
      end
   end

   // stage 2: dead zone, operand pick, quadrant turn
   logic [63:0]            r2;
   logic signed [64:0]     dot;
   logic signed [63:0]     bround;
   logic                   dead;
   logic signed [31:0]     ax, ay;
   pdmp_pkg::iter_type     s2_in, s2_ff;
   logic                   s2_v_ff;

   always_comb begin
      r2     = s1_xx_ff + s1_yy_ff;
      dot    = {s1_xdx_ff[63], s1_xdx_ff} + {s1_ydy_ff[63], s1_ydy_ff};
      bround = s1_bp_ff + 64'sd32768;
      dead   = (r2 < pdmp_pkg::DEAD_ZONE_R2) &&
               !(s1_req_ff.dir_x == 0 && s1_req_ff.dir_y == 0);
      ax     = dead ? s1_req_ff.dir_x : s1_req_ff.pos_x;
      ay     = dead ? s1_req_ff.dir_y : s1_req_ff.pos_y;
      s2_in.origin  = (ax == 0) && (ay == 0);
      s2_in.flip    = dead && dot[64];
      s2_in.sq_v    = r2;
      s2_in.sq_rem  = '0;
      s2_in.sq_q    = '0;
      s2_in.bterm   = bround[63:16];
      s2_in.ref_ang = s1_req_ff.reference_angle;
      if (ax < 0) begin
         if (ay >= 0) begin
            s2_in.cx = pdmp_pkg::CX_W'(ay);
            s2_in.cy = -pdmp_pkg::CX_W'(ax);
            s2_in.z  = pdmp_pkg::ANG_HALF_PI;
         end else begin
            s2_in.cx = -pdmp_pkg::CX_W'(ay);
            s2_in.cy = pdmp_pkg::CX_W'(ax);
            s2_in.z  = -pdmp_pkg::ANG_HALF_PI;
         end
      end else begin
         s2_in.cx = pdmp_pkg::CX_W'(ax);
         s2_in.cy = pdmp_pkg::CX_W'(ay);
         s2_in.z  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (advance) begin
         s2_v_ff <= s1_v_ff;
      end
      if (advance) begin
         s2_ff <= s2_in;
      end
   end

   logic               it_v;
   pdmp_pkg::iter_type it_d;

   pdmp_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_v_ff),
      .in_data   (s2_ff),
      .out_valid (it_v),
      .out_data  (it_d)
   );

   // stage A: heading flip, rounded radius, gantry sum
   logic signed [pdmp_pkg::Z_W-1:0] ang0, ang_a;
   logic [32:0]                     root;
   logic signed [pdmp_pkg::T_W-1:0] bt_ext, r_ext, t_a;
   logic                            sa_v_ff;
   logic signed [pdmp_pkg::Z_W-1:0] sa_ang_ff;
   logic signed [pdmp_pkg::T_W-1:0] sa_t_ff;
   logic signed [31:0]              sa_ref_ff;

   always_comb begin
      ang0 = it_d.origin ? '0 : it_d.z;
      ang_a = ang0;
      if (it_d.flip) begin
         ang_a = (ang0 > 0) ? ang0 - pdmp_pkg::ANG_PI : ang0 + pdmp_pkg::ANG_PI;
      end
      // remainder above root means v > q*q + q
      root   = {1'b0, it_d.sq_q} + 33'((it_d.sq_rem > {3'b000, it_d.sq_q}) ? 1 : 0);
      bt_ext = pdmp_pkg::T_W'(it_d.bterm);
      r_ext  = $signed(pdmp_pkg::T_W'(root));
      t_a    = (kind_ff == pdmp_pkg::KIND_PLUS) ? bt_ext + r_ext : bt_ext - r_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_v_ff <= 1'b0;
      end else if (advance) begin
         sa_v_ff <= it_v;
      end
      if (advance) begin
         sa_ang_ff <= ang_a;
         sa_t_ff   <= t_a;
         sa_ref_ff <= it_d.ref_ang;
      end
   end

   // stage B: unwrap, clip, select
   logic signed [pdmp_pkg::Z_W-1:0] diff, ang_b;
   pdmp_pkg::rsp_type               rsp_in, rsp_ff;
   logic                            rsp_v_ff;

   always_comb begin
      diff  = sa_ang_ff - pdmp_pkg::Z_W'(sa_ref_ff);
      ang_b = sa_ang_ff;
      if (diff > pdmp_pkg::ANG_PI) begin
         ang_b = sa_ang_ff - pdmp_pkg::ANG_TWO_PI;
      end else if (diff < -pdmp_pkg::ANG_PI) begin
         ang_b = sa_ang_ff + pdmp_pkg::ANG_TWO_PI;
      end
      rsp_in.motor_position = '0;
      rsp_in.saturated      = 1'b0;
      unique case (kind_ff)
         pdmp_pkg::KIND_BED: begin
            rsp_in.motor_position = ang_b[31:0];
         end
         pdmp_pkg::KIND_PLUS, pdmp_pkg::KIND_MINUS: begin
            if (sa_t_ff > pdmp_pkg::T_W'(64'sd2147483647)) begin
               rsp_in.motor_position = 32'sh7fffffff;
               rsp_in.saturated      = 1'b1;
            end else if (sa_t_ff < -pdmp_pkg::T_W'(64'sd2147483648)) begin
               rsp_in.motor_position = 32'sh80000000;
               rsp_in.saturated      = 1'b1;
            end else begin
               rsp_in.motor_position = sa_t_ff[31:0];
            end
         end
         default: begin
            rsp_in.motor_position = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (advance) begin
         rsp_v_ff <= sa_v_ff;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("held result changed");
   a_stall_back : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while output stalled");
   a_bed_nosat : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && kind_ff == pdmp_pkg::KIND_BED) |-> !rsp_data.saturated)
      else $error("bed angle flagged saturated");
   a_none_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && kind_ff == pdmp_pkg::KIND_NONE) |->
      (rsp_data.motor_position == 0 && !rsp_data.saturated))
      else $error("unused kind gave nonzero result");
`endif

endmodule
